[hw/rtl/rdms_pkg.sv]
// Shared types, codes and constants of the drive-mode sequencer.
package rdms_pkg;

    // Fixed limits
    localparam logic [4:0] TRIM_MAX_HALF = 5'd16;
    localparam logic [9:0] BACKOFF_WAIT  = 10'd15;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_ACTIVE_LEVEL    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRAIGHT_RUN_TICKS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRAIGHT_PAUSE_TICKS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN_RUN_TICKS       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN_PAUSE_TICKS     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_UTURN_TICKS          = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOUNCE_TICKS         = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_DEBOUNCE_TICKS   = 3'd7;

    // Configuration reset values
    localparam logic       RST_LINE_ACTIVE_LEVEL    = 1'b0;
    localparam logic [7:0] RST_STRAIGHT_RUN_TICKS   = 8'd10;
    localparam logic [7:0] RST_STRAIGHT_PAUSE_TICKS = 8'd6;
    localparam logic [7:0] RST_TURN_RUN_TICKS       = 8'd10;
    localparam logic [7:0] RST_TURN_PAUSE_TICKS     = 8'd4;
    localparam logic [9:0] RST_UTURN_TICKS          = 10'd300;
    localparam logic [9:0] RST_BOUNCE_TICKS         = 10'd150;
    localparam logic [7:0] RST_KEY_DEBOUNCE_TICKS   = 8'd20;
    localparam logic [4:0] RST_TRIM_HALF            = 5'd3;

    // Sequencer phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_DEBOUNCE   = 4'd1;
    localparam logic [3:0] PH_RELEASE    = 4'd2;
    localparam logic [3:0] PH_MOVE_RUN   = 4'd3;
    localparam logic [3:0] PH_MOVE_TRIM  = 4'd4;
    localparam logic [3:0] PH_MOVE_PAUSE = 4'd5;
    localparam logic [3:0] PH_BACK_RUN   = 4'd6;
    localparam logic [3:0] PH_BACK_TRIM  = 4'd7;
    localparam logic [3:0] PH_BACK_PAUSE = 4'd8;
    localparam logic [3:0] PH_BACK_WAIT  = 4'd9;
    localparam logic [3:0] PH_UTURN      = 4'd10;
    localparam logic [3:0] PH_BOUNCE_R   = 4'd11;
    localparam logic [3:0] PH_BOUNCE_L   = 4'd12;
    localparam logic [3:0] PH_SPIN_L     = 4'd13;
    localparam logic [3:0] PH_SPIN_R     = 4'd14;
    localparam logic [3:0] PH_TURN_PAUSE = 4'd15;

    // Motor drive codes
    localparam logic [1:0] D_OFF  = 2'd0;
    localparam logic [1:0] D_FWD  = 2'd1;
    localparam logic [1:0] D_BACK = 2'd2;

    // Drive modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_LINE   = 2'd1;
    localparam logic [1:0] MODE_REMOTE = 2'd2;

    // Remote moves
    localparam logic [2:0] MV_STOP = 3'd0;
    localparam logic [2:0] MV_F    = 3'd1;
    localparam logic [2:0] MV_B    = 3'd2;
    localparam logic [2:0] MV_L    = 3'd3;
    localparam logic [2:0] MV_R    = 3'd4;

    // Command characters (ASCII)
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_CASE_OFFSET = 8'd32;

    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       line_left_level;
        logic       line_right_level;
        logic       front_left_level;
        logic       front_right_level;
        logic       key_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0] left_drive;
        logic [1:0] right_drive;
        logic [1:0] drive_mode_out;
        logic [4:0] trim_out;
        logic       sequence_busy;
    } out_item_t;

    typedef struct packed {
        logic       line_active_level;
        logic [7:0] straight_run_ticks;
        logic [7:0] straight_pause_ticks;
        logic [7:0] turn_run_ticks;
        logic [7:0] turn_pause_ticks;
        logic [9:0] uturn_ticks;
        logic [9:0] bounce_ticks;
        logic [7:0] key_debounce_ticks;
    } cfg_t;

    // held_drive packs the left drive in [1:0] and the right drive in [3:2]
    typedef struct packed {
        logic [1:0] drive_mode;
        logic [2:0] remote_move;
        logic [4:0] trim_half;
        logic       trim_alternate;
        logic [7:0] pending_byte;
        logic       pending_flag;
        logic [3:0] seq_phase;
        logic [9:0] phase_ticks;
        logic [3:0] pulse_trim;
        logic       pulse_reverse;
        logic [3:0] held_drive;
    } seq_state_t;

    function automatic logic [3:0] drv(logic [1:0] l, logic [1:0] r);
        return {r, l};
    endfunction

endpackage

[hw/rtl/rdms_cfg.sv]
// Configuration register file of the drive-mode sequencer.
module rdms_cfg
    import rdms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Register writes, one register per write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_active_level    <= RST_LINE_ACTIVE_LEVEL;
            cfg_reg.straight_run_ticks   <= RST_STRAIGHT_RUN_TICKS;
            cfg_reg.straight_pause_ticks <= RST_STRAIGHT_PAUSE_TICKS;
            cfg_reg.turn_run_ticks       <= RST_TURN_RUN_TICKS;
            cfg_reg.turn_pause_ticks     <= RST_TURN_PAUSE_TICKS;
            cfg_reg.uturn_ticks          <= RST_UTURN_TICKS;
            cfg_reg.bounce_ticks         <= RST_BOUNCE_TICKS;
            cfg_reg.key_debounce_ticks   <= RST_KEY_DEBOUNCE_TICKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_LINE_ACTIVE_LEVEL:    cfg_reg.line_active_level    <= cfg_wr_data[0];
                CFG_STRAIGHT_RUN_TICKS:   cfg_reg.straight_run_ticks   <= cfg_wr_data[7:0];
                CFG_STRAIGHT_PAUSE_TICKS: cfg_reg.straight_pause_ticks <= cfg_wr_data[7:0];
                CFG_TURN_RUN_TICKS:       cfg_reg.turn_run_ticks       <= cfg_wr_data[7:0];
                CFG_TURN_PAUSE_TICKS:     cfg_reg.turn_pause_ticks     <= cfg_wr_data[7:0];
                CFG_UTURN_TICKS:          cfg_reg.uturn_ticks          <= cfg_wr_data[9:0];
                CFG_BOUNCE_TICKS:         cfg_reg.bounce_ticks         <= cfg_wr_data[9:0];
                CFG_KEY_DEBOUNCE_TICKS:   cfg_reg.key_debounce_ticks   <= cfg_wr_data[7:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/rdms_core.sv]
// Sequencer state registers and the one-tick next-state logic.
module rdms_core
    import rdms_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    seq_state_t state_reg;
    seq_state_t state_next;
    logic       step_started;

    // ---- phase helpers ----
    function automatic seq_state_t set_phase(seq_state_t s, logic [3:0] ph,
                                             logic [9:0] n, logic [3:0] d);
        s.seq_phase   = ph;
        s.phase_ticks = n;
        s.held_drive  = d;
        return s;
    endfunction

    function automatic seq_state_t end_seq(seq_state_t s);
        s.seq_phase   = PH_IDLE;
        s.phase_ticks = '0;
        s.held_drive  = drv(D_OFF, D_OFF);
        return s;
    endfunction

    // Straight pulse; odd trims alternate floor and ceiling of half
    function automatic seq_state_t start_pulse(seq_state_t s, cfg_t c, logic rev,
                                               logic backoff);
        logic [4:0] t;
        logic [7:0] trim8;
        logic [7:0] common;
        logic [1:0] d;
        t = s.trim_half >> 1;
        if (s.trim_half[0]) begin
            s.trim_alternate = ~s.trim_alternate;
            if (s.trim_alternate) t = t + 5'd1;
        end
        s.pulse_trim    = t[3:0];
        s.pulse_reverse = rev;
        trim8 = {4'd0, s.pulse_trim};
        if (trim8 >= c.straight_run_ticks) common = 8'd1;
        else common = c.straight_run_ticks - trim8;
        d = rev ? D_BACK : D_FWD;
        return set_phase(s, backoff ? PH_BACK_RUN : PH_MOVE_RUN, {2'd0, common}, drv(d, d));
    endfunction

    function automatic seq_state_t after_move_trim(seq_state_t s, cfg_t c);
        if (c.straight_pause_ticks != 8'd0)
            return set_phase(s, PH_MOVE_PAUSE, {2'd0, c.straight_pause_ticks},
                             drv(D_OFF, D_OFF));
        return end_seq(s);
    endfunction

    function automatic seq_state_t after_move_run(seq_state_t s, cfg_t c);
        logic [1:0] d;
        d = s.pulse_reverse ? D_BACK : D_FWD;
        if (s.pulse_trim != 4'd0)
            return set_phase(s, PH_MOVE_TRIM, {6'd0, s.pulse_trim}, drv(D_OFF, d));
        return after_move_trim(s, c);
    endfunction

    // Keep backing off while either front sensor is blocked, then u-turn if a u-turn time is set
    function automatic seq_state_t backoff_check(seq_state_t s, cfg_t c, in_item_t i);
        if (!i.front_left_level || !i.front_right_level) return start_pulse(s, c, 1'b1, 1'b1);
        if (c.uturn_ticks != 10'd0)
            return set_phase(s, PH_UTURN, c.uturn_ticks, drv(D_FWD, D_BACK));
        return end_seq(s);
    endfunction

    function automatic seq_state_t after_back_pause(seq_state_t s, cfg_t c, in_item_t i);
        if (BACKOFF_WAIT != 10'd0)
            return set_phase(s, PH_BACK_WAIT, BACKOFF_WAIT, drv(D_OFF, D_OFF));
        return backoff_check(s, c, i);
    endfunction

    function automatic seq_state_t after_back_trim(seq_state_t s, cfg_t c, in_item_t i);
        if (c.straight_pause_ticks != 8'd0)
            return set_phase(s, PH_BACK_PAUSE, {2'd0, c.straight_pause_ticks},
                             drv(D_OFF, D_OFF));
        return after_back_pause(s, c, i);
    endfunction

    function automatic seq_state_t after_back_run(seq_state_t s, cfg_t c, in_item_t i);
        if (s.pulse_trim != 4'd0)
            return set_phase(s, PH_BACK_TRIM, {6'd0, s.pulse_trim}, drv(D_OFF, D_BACK));
        return after_back_trim(s, c, i);
    endfunction

    function automatic seq_state_t after_spin(seq_state_t s, cfg_t c);
        if (c.turn_pause_ticks != 8'd0)
            return set_phase(s, PH_TURN_PAUSE, {2'd0, c.turn_pause_ticks},
                             drv(D_OFF, D_OFF));
        return end_seq(s);
    endfunction

    function automatic seq_state_t start_spin(seq_state_t s, cfg_t c, logic left);
        if (c.turn_run_ticks == 8'd0) return after_spin(s, c);
        if (left)
            return set_phase(s, PH_SPIN_L, {2'd0, c.turn_run_ticks}, drv(D_BACK, D_FWD));
        return set_phase(s, PH_SPIN_R, {2'd0, c.turn_run_ticks}, drv(D_FWD, D_BACK));
    endfunction

    // One move of the current mode
    function automatic seq_state_t mode_step(seq_state_t s, cfg_t c, in_item_t i);
        logic l;
        logic r;
        seq_state_t o;
        l = (i.line_left_level == c.line_active_level);
        r = (i.line_right_level == c.line_active_level);
        o = end_seq(s);
        priority if (s.drive_mode == MODE_LINE) begin
            priority if (l && r) o = start_pulse(s, c, 1'b0, 1'b0);
            else if (l)          o = start_spin(s, c, 1'b0);
            else if (r)          o = start_spin(s, c, 1'b1);
            else                 o = end_seq(s);
        end else if (s.drive_mode == MODE_REMOTE) begin
            unique case (s.remote_move)
                MV_F:    o = start_pulse(s, c, 1'b0, 1'b0);
                MV_B:    o = start_pulse(s, c, 1'b1, 1'b0);
                MV_L:    o = start_spin(s, c, 1'b1);
                MV_R:    o = start_spin(s, c, 1'b0);
                default: o = end_seq(s);
            endcase
        end else begin
            o = end_seq(s);
        end
        return o;
    endfunction

    function automatic seq_state_t obstacle_step(seq_state_t s, cfg_t c, in_item_t i);
        logic lo;
        logic ro;
        lo = ~i.front_left_level;
        ro = ~i.front_right_level;
        if (!lo && !ro) return mode_step(s, c, i);
        s = end_seq(s);
        if (lo && ro) return start_pulse(s, c, 1'b1, 1'b1);
        if (c.bounce_ticks == 10'd0) return s;
        if (lo) return set_phase(s, PH_BOUNCE_R, c.bounce_ticks, drv(D_FWD, D_BACK));
        return set_phase(s, PH_BOUNCE_L, c.bounce_ticks, drv(D_BACK, D_FWD));
    endfunction

    // Consume the pending command byte, if any
    function automatic seq_state_t command_step(seq_state_t s);
        logic [7:0] ch;
        if (!s.pending_flag) return s;
        s.pending_flag = 1'b0;
        ch = s.pending_byte;
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ch = ch - CH_CASE_OFFSET;
        unique case (ch)
            CH_F: begin s.drive_mode = MODE_REMOTE; s.remote_move = MV_F; end
            CH_B: begin s.drive_mode = MODE_REMOTE; s.remote_move = MV_B; end
            CH_L: begin s.drive_mode = MODE_REMOTE; s.remote_move = MV_L; end
            CH_R: begin s.drive_mode = MODE_REMOTE; s.remote_move = MV_R; end
            CH_S, CH_M: begin
                s.drive_mode  = MODE_IDLE;
                s.remote_move = MV_STOP;
                s.held_drive  = drv(D_OFF, D_OFF);
            end
            CH_A: begin s.drive_mode = MODE_LINE; s.remote_move = MV_STOP; end
            CH_PLUS:  if (s.trim_half < TRIM_MAX_HALF) s.trim_half = s.trim_half + 5'd1;
            CH_MINUS: if (s.trim_half != 5'd0) s.trim_half = s.trim_half - 5'd1;
            CH_ZERO:  s.trim_half = 5'd0;
            default: ;
        endcase
        return s;
    endfunction

    function automatic seq_state_t after_release(seq_state_t s, cfg_t c, in_item_t i);
        s.seq_phase   = PH_IDLE;
        s.phase_ticks = '0;
        s = command_step(s);
        return obstacle_step(s, c, i);
    endfunction

    // Key still pressed after debounce: toggle line follow, wait for release
    function automatic seq_state_t after_debounce(seq_state_t s, cfg_t c, in_item_t i);
        if (i.key_level) return after_release(s, c, i);
        if (s.drive_mode == MODE_LINE) begin
            s.drive_mode = MODE_IDLE;
            s.held_drive = drv(D_OFF, D_OFF);
        end else begin
            s.drive_mode = MODE_LINE;
        end
        s.seq_phase   = PH_RELEASE;
        s.phase_ticks = '0;
        return s;
    endfunction

    function automatic seq_state_t start_pass(seq_state_t s, cfg_t c, in_item_t i);
        if (i.key_level) return after_release(s, c, i);
        if (c.key_debounce_ticks != 8'd0)
            return set_phase(s, PH_DEBOUNCE, {2'd0, c.key_debounce_ticks}, s.held_drive);
        return after_debounce(s, c, i);
    endfunction

    function automatic seq_state_t advance(seq_state_t s, cfg_t c, in_item_t i);
        seq_state_t o;
        unique case (s.seq_phase)
            PH_DEBOUNCE:   o = after_debounce(s, c, i);
            PH_MOVE_RUN:   o = after_move_run(s, c);
            PH_MOVE_TRIM:  o = after_move_trim(s, c);
            PH_BACK_RUN:   o = after_back_run(s, c, i);
            PH_BACK_TRIM:  o = after_back_trim(s, c, i);
            PH_BACK_PAUSE: o = after_back_pause(s, c, i);
            PH_BACK_WAIT:  o = backoff_check(s, c, i);
            PH_SPIN_L, PH_SPIN_R: o = after_spin(s, c);
            default:       o = end_seq(s);
        endcase
        return o;
    endfunction

    // ---- one tick ----
    always_comb begin
        state_next   = state_reg;
        step_started = 1'b0;
        if (item.rx_valid) begin
            state_next.pending_byte = item.rx_byte;
            state_next.pending_flag = 1'b1;
        end
        // a phase still counting down takes none of these branches
        if (state_next.seq_phase == PH_IDLE) begin
            state_next   = start_pass(state_next, cfg, item);
            step_started = 1'b1;
        end else if (state_next.seq_phase == PH_RELEASE) begin
            if (item.key_level) state_next = after_release(state_next, cfg, item);
        end else if (state_next.phase_ticks == 10'd0) begin
            state_next = advance(state_next, cfg, item);
        end
        // at most one new pass per tick
        if (state_next.seq_phase == PH_IDLE && !step_started)
            state_next = start_pass(state_next, cfg, item);
        if (state_next.seq_phase != PH_IDLE && state_next.seq_phase != PH_RELEASE &&
            state_next.phase_ticks != 10'd0)
            state_next.phase_ticks = state_next.phase_ticks - 10'd1;
    end

    // State update per processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.drive_mode     <= MODE_IDLE;
            state_reg.remote_move    <= MV_STOP;
            state_reg.trim_half      <= RST_TRIM_HALF;
            state_reg.trim_alternate <= 1'b0;
            state_reg.pending_byte   <= 8'd0;
            state_reg.pending_flag   <= 1'b0;
            state_reg.seq_phase      <= PH_IDLE;
            state_reg.phase_ticks    <= '0;
            state_reg.pulse_trim     <= 4'd0;
            state_reg.pulse_reverse  <= 1'b0;
            state_reg.held_drive     <= drv(D_OFF, D_OFF);
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    // Result of this tick
    assign result.left_drive     = state_next.held_drive[1:0];
    assign result.right_drive    = state_next.held_drive[3:2];
    assign result.drive_mode_out = state_next.drive_mode;
    assign result.trim_out       = state_next.trim_half;
    assign result.sequence_busy  = (state_next.seq_phase != PH_IDLE);

endmodule

[hw/rtl/robot_drive_mode_sequencer.sv]
// Path: input register, sequencer core, result register. Throughput: one tick
// per clock while the result register is free or drains; the state update of
// the sequencer core is combinational between the two registers.
// The input register can take a new tick while a finished result waits.
// Reset: synchronous, active-low aresetn returns configuration to defaults,
// mode idle, trim 3, no pending command, no sequence, both motors off.
module robot_drive_mode_sequencer
    import rdms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t m_item_reg;
    logic      m_valid_reg;
    out_item_t result;
    logic      out_load;

    rdms_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Handshake: the tick moves on when the result register is free or drains
    assign out_load = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;

    rdms_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (out_load),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (out_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A processed tick always lands in the result register
    a_load_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("processed tick did not reach the result register");

    // Input stage only pushes back while it holds a tick
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input held off without a stalled result");

    // No running sequence means both motors off
    a_idle_motors_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_item_reg.sequence_busy) |->
            (m_item_reg.left_drive == D_OFF && m_item_reg.right_drive == D_OFF))
        else $error("motors driven with no sequence running");

    // Trim never passes its ceiling
    a_trim_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_item_reg.trim_out <= TRIM_MAX_HALF)
        else $error("trim above its maximum");

endmodule
